// ----- hw/rtl/pdca_pkg.sv -----
// Shared types and constants for the power diagram cell assignment block.
`default_nettype none

package pdca_pkg;

  localparam int COORD_W  = 16;
  localparam int WEIGHT_W = 40;
  localparam int INDEX_W  = 6;
  localparam int COUNT_W  = 7;
  localparam int POWER_W  = 41;
  localparam int DIFF_W   = COORD_W + 1;
  localparam int SQ_W     = 2 * COORD_W + 1;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // One generator as it is kept in the table.
  typedef struct packed {
    logic signed [COORD_W-1:0]  x;
    logic signed [COORD_W-1:0]  y;
    logic signed [COORD_W-1:0]  z;
    logic signed [WEIGHT_W-1:0] w;
  } entry_t;

  // A classified command passed from the front queue to the back end.
  typedef struct packed {
    logic                       is_query;
    logic [INDEX_W-1:0]         index;
    logic signed [COORD_W-1:0]  x;
    logic signed [COORD_W-1:0]  y;
    logic signed [COORD_W-1:0]  z;
    logic signed [WEIGHT_W-1:0] w;
  } cmd_t;

endpackage

`default_nettype wire

// ----- hw/rtl/pdca_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none

module pdca_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- hw/rtl/pdca_front.sv -----
// Front end: accepts input items, classifies them and queues commands for the back end.
`default_nettype none

module pdca_front #(
  parameter int MAX_GENERATORS = 64
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                push,
  output      logic                                full,
  input  wire logic                                op,
  input  wire logic [pdca_pkg::INDEX_W-1:0]        entry_index,
  input  wire logic signed [pdca_pkg::COORD_W-1:0] point_x,
  input  wire logic signed [pdca_pkg::COORD_W-1:0] point_y,
  input  wire logic signed [pdca_pkg::COORD_W-1:0] point_z,
  input  wire logic signed [pdca_pkg::WEIGHT_W-1:0] weight,
  output      pdca_pkg::cmd_t                      cmd,
  output      logic                                cmd_valid,
  input  wire logic                                cmd_take
);

  import pdca_pkg::*;

  cmd_t       q [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  logic       accept;
  logic       in_range;
  logic       enq;
  logic       deq;

  assign full      = (fill == 2'd2);
  assign accept    = push && !full;
  assign in_range  = ({{(32-INDEX_W){1'b0}}, entry_index} < MAX_GENERATORS);
  // A load aimed beyond the table is taken and dropped here.
  assign enq       = accept && ((op == OP_QUERY) || in_range);
  assign cmd_valid = (fill != 2'd0);
  assign deq       = cmd_take && cmd_valid;
  assign cmd       = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (enq) begin
      q[wr_ptr] <= '{is_query: (op == OP_QUERY), index: entry_index,
                     x: point_x, y: point_y, z: point_z, w: weight};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (enq) begin
        wr_ptr <= !wr_ptr;
      end
      if (deq) begin
        rd_ptr <= !rd_ptr;
      end
      if (enq && !deq) begin
        fill <= fill + 2'd1;
      end else if (deq && !enq) begin
        fill <= fill - 2'd1;
      end
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/pdca_back.sv -----
// Back end: writes generators and scans the table through a power-distance pipeline.
`default_nettype none

module pdca_back #(
  parameter int MAX_GENERATORS = 64
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire pdca_pkg::cmd_t                       cmd,
  input  wire logic                                 cmd_valid,
  output      logic                                 cmd_take,
  input  wire logic [pdca_pkg::COUNT_W-1:0]         active_count,
  output      logic                                 ram_we,
  output      logic [$clog2(MAX_GENERATORS)-1:0]    ram_waddr,
  output      pdca_pkg::entry_t                     ram_wdata,
  output      logic [$clog2(MAX_GENERATORS)-1:0]    ram_raddr,
  input  wire pdca_pkg::entry_t                     ram_rdata,
  output      logic                                 empty,
  input  wire logic                                 pop,
  output      logic [pdca_pkg::INDEX_W-1:0]         region,
  output      logic signed [pdca_pkg::POWER_W-1:0]  min_power
);

  import pdca_pkg::*;

  localparam int AW = $clog2(MAX_GENERATORS);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SCAN   = 4'b0010,
    ST_DRAIN  = 4'b0100,
    ST_FINISH = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  logic signed [COORD_W-1:0] qx;
  logic signed [COORD_W-1:0] qy;
  logic signed [COORD_W-1:0] qz;
  logic [COUNT_W-1:0]        idx;
  logic [COUNT_W-1:0]        last_idx;
  logic                      at_last;
  logic                      issue;
  logic                      res_load;

  // Pipeline: read, difference, square, power, compare.
  logic                       v0, v1, v2, v3;
  logic                       last0, last1, last2, last3;
  logic [COUNT_W-1:0]         tag0, tag1, tag2, tag3;
  logic signed [DIFF_W-1:0]   dx, dy, dz;
  logic signed [WEIGHT_W-1:0] w1, w2;
  logic [SQ_W-1:0]            sqx, sqy, sqz;
  logic signed [POWER_W-1:0]  pw;
  logic signed [2*DIFF_W-1:0] sqx_full, sqy_full, sqz_full;
  logic signed [POWER_W-1:0]  best;
  logic [COUNT_W-1:0]         best_idx;
  logic                       done;
  logic                       res_valid;

  assign last_idx = active_count - COUNT_W'(1);
  assign at_last  = (idx == last_idx);
  assign issue    = (state == ST_SCAN);
  assign cmd_take = (state == ST_IDLE) && cmd_valid;
  assign res_load = (state == ST_FINISH) && (!res_valid || pop);

  assign ram_we    = cmd_take && !cmd.is_query;
  assign ram_waddr = AW'(cmd.index);
  assign ram_wdata = '{x: cmd.x, y: cmd.y, z: cmd.z, w: cmd.w};
  assign ram_raddr = AW'(idx);

  assign sqx_full = dx * dx;
  assign sqy_full = dy * dy;
  assign sqz_full = dz * dz;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (cmd_take && cmd.is_query) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (at_last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (done) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (res_load) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      v0        <= 1'b0;
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      done      <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      state     <= state_next;
      v0        <= issue;
      v1        <= v0;
      v2        <= v1;
      v3        <= v2;
      done      <= v3 && last3;
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (pop) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_take && cmd.is_query) begin
      qx  <= cmd.x;
      qy  <= cmd.y;
      qz  <= cmd.z;
      idx <= '0;
    end else if (issue) begin
      idx <= idx + COUNT_W'(1);
    end

    tag0  <= idx;
    last0 <= at_last;

    tag1  <= tag0;
    last1 <= last0;
    dx    <= DIFF_W'(qx) - DIFF_W'(ram_rdata.x);
    dy    <= DIFF_W'(qy) - DIFF_W'(ram_rdata.y);
    dz    <= DIFF_W'(qz) - DIFF_W'(ram_rdata.z);
    w1    <= ram_rdata.w;

    tag2  <= tag1;
    last2 <= last1;
    sqx   <= sqx_full[SQ_W-1:0];
    sqy   <= sqy_full[SQ_W-1:0];
    sqz   <= sqz_full[SQ_W-1:0];
    w2    <= w1;

    tag3  <= tag2;
    last3 <= last2;
    pw    <= POWER_W'(sqx) + POWER_W'(sqy) + POWER_W'(sqz) - POWER_W'(w2);

    // Strict less-than keeps the lowest index on ties; slot zero starts the scan.
    if (v3 && ((tag3 == '0) || (pw < best))) begin
      best     <= pw;
      best_idx <= tag3;
    end

    if (res_load) begin
      region    <= best_idx[INDEX_W-1:0];
      min_power <= best;
    end
  end

  assign empty = !res_valid;

endmodule

`default_nettype wire

// ----- hw/rtl/power_diagram_cell_assign_unit.sv -----
// Top level of the power diagram cell assignment block.
`default_nettype none

// Holds up to MAX_GENERATORS weighted 3-D generators and, for each query point,
// returns the generator with the least power distance (squared distance minus
// weight) among the first generator_count entries, lowest index on ties. A count
// of zero scans slot zero only, and a count past the table scans the whole table.
// A load gives no result. A query takes the command, then reads the first n
// table entries one generator per cycle through its single read port, where n
// is generator_count clipped to 1..MAX_GENERATORS, then empties the four-stage
// difference, square, sum and compare pipeline and loads the result register.
// That load waits while the result register still holds an unpopped result.
// A two-entry command queue lets items be pushed while a query is scanning, and
// the result register lets the next command start before the previous result is
// popped. Only generators that have been loaded may be queried.
module power_diagram_cell_assign_unit #(
  parameter int MAX_GENERATORS = 64
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  push,
  output      logic                                  full,
  input  wire logic                                  op,
  input  wire logic [pdca_pkg::INDEX_W-1:0]          entry_index,
  input  wire logic signed [pdca_pkg::COORD_W-1:0]   point_x,
  input  wire logic signed [pdca_pkg::COORD_W-1:0]   point_y,
  input  wire logic signed [pdca_pkg::COORD_W-1:0]   point_z,
  input  wire logic signed [pdca_pkg::WEIGHT_W-1:0]  weight,
  output      logic                                  empty,
  input  wire logic                                  pop,
  output      logic [pdca_pkg::INDEX_W-1:0]          region,
  output      logic signed [pdca_pkg::POWER_W-1:0]   min_power,
  input  wire logic                                  cfg_we,
  input  wire logic [pdca_pkg::COUNT_W-1:0]          cfg_wdata
);

  import pdca_pkg::*;

  localparam int AW = $clog2(MAX_GENERATORS);

  logic [COUNT_W-1:0] generator_count;
  logic [COUNT_W-1:0] active_count;
  cmd_t               cmd;
  logic               cmd_valid;
  logic               cmd_take;
  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [AW-1:0]      ram_raddr;
  entry_t             ram_wdata;
  entry_t             ram_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      generator_count <= COUNT_W'(1);
    end else if (cfg_we) begin
      generator_count <= cfg_wdata;
    end
  end

  // A count of zero still scans slot zero; a count past the table is clipped.
  always_comb begin
    if (generator_count == '0) begin
      active_count = COUNT_W'(1);
    end else if ({{(32-COUNT_W){1'b0}}, generator_count} > MAX_GENERATORS) begin
      active_count = COUNT_W'(MAX_GENERATORS);
    end else begin
      active_count = generator_count;
    end
  end

  pdca_front #(
    .MAX_GENERATORS(MAX_GENERATORS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .op          (op),
    .entry_index (entry_index),
    .point_x     (point_x),
    .point_y     (point_y),
    .point_z     (point_z),
    .weight      (weight),
    .cmd         (cmd),
    .cmd_valid   (cmd_valid),
    .cmd_take    (cmd_take)
  );

  pdca_ram #(
    .WIDTH($bits(entry_t)),
    .DEPTH(MAX_GENERATORS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  pdca_back #(
    .MAX_GENERATORS(MAX_GENERATORS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .cmd_valid    (cmd_valid),
    .cmd_take     (cmd_take),
    .active_count (active_count),
    .ram_we       (ram_we),
    .ram_waddr    (ram_waddr),
    .ram_wdata    (ram_wdata),
    .ram_raddr    (ram_raddr),
    .ram_rdata    (ram_rdata),
    .empty        (empty),
    .pop          (pop),
    .region       (region),
    .min_power    (min_power)
  );

endmodule

`default_nettype wire
